/* rtl/core/coo_sort_pkg.sv */
// Shared types and defaults for the coordinate-form row-major sorter.
// Used by the channel interfaces, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package coo_sort_pkg;

	localparam int INDEX_W           = 16;
	localparam int VALUE_W           = 32;
	localparam int DEF_MAX_ENTRIES   = 64;
	localparam int DEF_INDEX_BITS    = 16;

	typedef struct packed {
		logic [INDEX_W-1:0] row_index;
		logic [INDEX_W-1:0] col_index;
		logic [VALUE_W-1:0] value_bits;
		logic               last_entry;
	} coo_in_t;

	typedef struct packed {
		logic [INDEX_W-1:0] row_out;
		logic [INDEX_W-1:0] col_out;
		logic [VALUE_W-1:0] value_out;
		logic               last_out;
		logic               overflow_out;
	} coo_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_EMIT_RD,
		ST_EMIT_LD
	} sort_state_t;

endpackage

`default_nettype wire

/* rtl/core/coo_sort_if.sv */
// Valid/ready channel interfaces for entries in and sorted results out.
// Depends on coo_sort_pkg for the payload structs.
`timescale 1ns / 1ps
`default_nettype none

interface coo_sort_in_if;
	logic                  valid;
	logic                  ready;
	coo_sort_pkg::coo_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface coo_sort_out_if;
	logic                   valid;
	logic                   ready;
	coo_sort_pkg::coo_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/coo_row_major_sorter_top.sv */
// Top level of the coordinate-form row-major sorter.
// Depends on coo_sort_pkg, coo_sort_if (channels) and coo_sort_ram (entry store).
`timescale 1ns / 1ps
`default_nettype none

// Sparse-matrix entries (row, column, 32-bit value bits) arrive one transfer at
// a time on the entries channel and are kept sorted by row, then column, in a
// single RAM of MAX_ENTRIES words. Each entry is placed by insertion: the block
// walks down from the top of the occupied region, reading one stored word per
// step and moving it up one slot while its key is larger than the new key, so
// equal keys keep arrival order. Each step issues the registered RAM read in
// ST_INS_RD, then compares and writes in ST_INS_CMP. Only the low INDEX_BITS of
// the row and column are kept; upper bits read back as zero. An entry marked
// last starts emission of the whole store in order, pausing while the output
// register holds a result not yet taken, with last_out on the final result;
// the count then drops to zero. An entry arriving while the store is full is
// dropped and sets a sticky overflow flag that only reset clears and that rides
// on every result. The entries channel is ready only while the block is idle;
// the final result may still sit in the output register while the next set
// loads.
module coo_row_major_sorter_top #(
	parameter int MAX_ENTRIES = coo_sort_pkg::DEF_MAX_ENTRIES,
	parameter int INDEX_BITS  = coo_sort_pkg::DEF_INDEX_BITS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	coo_sort_in_if.sink     entries,
	coo_sort_out_if.source  results
);

	import coo_sort_pkg::*;

	localparam int AW    = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int KEY_W = 2 * INDEX_BITS;
	localparam int ENT_W = KEY_W + VALUE_W;

	sort_state_t state_q, state_d;

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [AW-1:0]    pos_q;
	logic [AW-1:0]    emit_idx_q;
	logic [ENT_W-1:0] new_q;
	logic             last_q;
	coo_out_t         out_q;
	logic             out_valid_q;

	// RAM port signals
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [ENT_W-1:0] wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [ENT_W-1:0] rd_data;

	logic             in_xfer;
	logic             out_xfer;
	logic             full;
	logic             shift_up;
	logic             emit_last;
	logic             out_free;

	assign in_xfer   = entries.valid && entries.ready;
	assign out_xfer  = results.valid && results.ready;
	assign full      = (count_q >= CNT_W'(MAX_ENTRIES));
	// Stored key strictly above the new key: move the stored word up one slot.
	assign shift_up  = (rd_data[ENT_W-1:VALUE_W] > new_q[ENT_W-1:VALUE_W]);
	assign emit_last = ((CNT_W'(emit_idx_q) + CNT_W'(1)) == count_q);
	// Output register can take a word at the next edge.
	assign out_free  = !out_valid_q || results.ready;

	coo_sort_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_ENTRIES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (!full) begin
						state_d = ST_INS_RD;
					end else if (entries.data.last_entry) begin
						state_d = ST_EMIT_RD;
					end
				end
			end
			ST_INS_RD: begin
				if (pos_q == '0) begin
					state_d = last_q ? ST_EMIT_RD : ST_IDLE;
				end else begin
					state_d = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				if (shift_up) begin
					state_d = ST_INS_RD;
				end else begin
					state_d = last_q ? ST_EMIT_RD : ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				if (out_free) begin
					state_d = ST_EMIT_LD;
				end
			end
			ST_EMIT_LD: begin
				state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM control and channel ready
	always_comb begin
		entries.ready = 1'b0;
		wr_en         = 1'b0;
		wr_addr       = pos_q;
		wr_data       = new_q;
		rd_en         = 1'b0;
		rd_addr       = pos_q - AW'(1);
		case (state_q)
			ST_IDLE: begin
				entries.ready = 1'b1;
			end
			ST_INS_RD: begin
				// Bottom reached: drop the new entry into slot zero.
				if (pos_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en = 1'b1;
				end
			end
			ST_INS_CMP: begin
				wr_en   = 1'b1;
				wr_data = shift_up ? rd_data : new_q;
			end
			ST_EMIT_RD: begin
				rd_addr = emit_idx_q;
				rd_en   = out_free;
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer && full) begin
				ovf_q <= 1'b1;
			end
			if (((state_q == ST_INS_RD) && (pos_q == '0)) ||
			    ((state_q == ST_INS_CMP) && !shift_up)) begin
				count_q <= count_q + CNT_W'(1);
			end
			if ((state_q == ST_EMIT_LD) && emit_last) begin
				count_q <= '0;
			end
			if (state_q == ST_EMIT_LD) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and walk pointers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			new_q      <= {entries.data.row_index[INDEX_BITS-1:0],
			               entries.data.col_index[INDEX_BITS-1:0],
			               entries.data.value_bits};
			last_q     <= entries.data.last_entry;
			pos_q      <= count_q[AW-1:0];
			emit_idx_q <= '0;
		end
		if ((state_q == ST_INS_CMP) && shift_up) begin
			pos_q <= pos_q - AW'(1);
		end
		if (state_q == ST_EMIT_LD) begin
			out_q.row_out      <= INDEX_W'(rd_data[ENT_W-1:KEY_W - INDEX_BITS + VALUE_W]);
			out_q.col_out      <= INDEX_W'(rd_data[VALUE_W + INDEX_BITS - 1:VALUE_W]);
			out_q.value_out    <= rd_data[VALUE_W-1:0];
			out_q.last_out     <= emit_last;
			out_q.overflow_out <= ovf_q;
			emit_idx_q         <= emit_idx_q + AW'(1);
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

endmodule

`default_nettype wire

/* rtl/core/coo_sort_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module coo_sort_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* tb/sv/coo_row_major_sorter_top_tb.sv */
// Self-checking testbench for coo_row_major_sorter_top: drives entry sets and
// checks every sorted result against a row/column insertion-sort predictor.
// Depends on coo_sort_pkg, the coo_sort_if channel interfaces and the RTL.
`timescale 1ns / 1ps

module coo_row_major_sorter_top_tb;
	import coo_sort_pkg::*;

	localparam int MAX_ENTRIES  = DEF_MAX_ENTRIES;
	localparam int INDEX_BITS   = DEF_INDEX_BITS;
	// Long receiver hold-off: the output register fills, emission stalls and
	// the entries channel stays closed while the sender keeps offering.
	localparam int HOLD_CYCLES  = 600;
	// Worst gap between transfers: the hold-off above, or a full-store
	// insertion behind a sender gap. Take it well over.
	localparam int STALL_LIMIT  = 4000;
	// Drain time after the last expected result: one full insertion plus slack.
	localparam int DRAIN_CYCLES = 4 * MAX_ENTRIES + 50;

	// Keeps the entries of the open set in row-major order and the results
	// that the block still owes.
	class sorted_entry_scoreboard;
		logic [63:0] held_entries[$];
		coo_out_t    due_results[$];
		bit          dropped_seen;
		int          capacity;
		logic [15:0] index_mask;
		int          errors;

		function new(int cap, int idx_bits);
			capacity     = cap;
			index_mask   = 16'((32'd1 << idx_bits) - 1);
			dropped_seen = 1'b0;
			errors       = 0;
		endfunction

		// Insert behind every held entry with the same or smaller key, so ties
		// keep arrival order; flush the whole set on a last entry.
		function void note_entry(coo_in_t e);
			logic [63:0] word;
			logic [31:0] key;
			int          pos;
			coo_out_t    r;
			word = {e.row_index & index_mask, e.col_index & index_mask, e.value_bits};
			key  = word[63:32];
			if (held_entries.size() < capacity) begin
				pos = held_entries.size();
				while (pos > 0 && held_entries[pos-1][63:32] > key)
					pos--;
				held_entries.insert(pos, word);
			end else begin
				dropped_seen = 1'b1;
			end
			if (e.last_entry) begin
				for (int i = 0; i < held_entries.size(); i++) begin
					r.row_out      = held_entries[i][63:48];
					r.col_out      = held_entries[i][47:32];
					r.value_out    = held_entries[i][31:0];
					r.last_out     = (i == held_entries.size() - 1);
					r.overflow_out = dropped_seen;
					due_results.insert(due_results.size(), r);
				end
				held_entries.delete();
			end
		endfunction

		function void check_result(coo_out_t got);
			coo_out_t want;
			if (due_results.size() == 0) begin
				$error("result with nothing due: row %0h col %0h value %0h",
					got.row_out, got.col_out, got.value_out);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (got.row_out !== want.row_out) begin
				$error("row_out: expected %0h, got %0h", want.row_out, got.row_out);
				errors++;
			end
			if (got.col_out !== want.col_out) begin
				$error("col_out: expected %0h, got %0h", want.col_out, got.col_out);
				errors++;
			end
			if (got.value_out !== want.value_out) begin
				$error("value_out: expected %0h, got %0h", want.value_out, got.value_out);
				errors++;
			end
			if (got.last_out !== want.last_out) begin
				$error("last_out: expected %0b, got %0b", want.last_out, got.last_out);
				errors++;
			end
			if (got.overflow_out !== want.overflow_out) begin
				$error("overflow_out: expected %0b, got %0b",
					want.overflow_out, got.overflow_out);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	coo_sort_in_if  entries_ch();
	coo_sort_out_if results_ch();

	coo_row_major_sorter_top #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.INDEX_BITS  (INDEX_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.entries (entries_ch),
		.results (results_ch)
	);

	sorted_entry_scoreboard sb = new(MAX_ENTRIES, INDEX_BITS);

	int send_idle_pct;
	int recv_idle_pct;
	int hold_token;
	int hold_seen;
	int hold_left;
	int stall_cycles;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Receiver: run a requested hold-off to completion, otherwise drop ready
	// at the phase's idle rate. One assignment to ready per edge.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			results_ch.ready <= 1'b0;
		end else begin
			results_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Sample at the falling edge: valid, ready and data are settled there and
	// a transfer seen now completes at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready)
			sb.check_result(results_ch.data);
	end

	// Watchdog: end the run when neither channel moves a transfer for too long.
	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(negedge clk);
			if (!arst_n)
				stall_cycles = 0;
			else if ((entries_ch.valid && entries_ch.ready) ||
				(results_ch.valid && results_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic coo_in_t make_fields(logic [15:0] row, logic [15:0] col,
		logic [31:0] value, logic last);
		coo_in_t e;
		e.row_index  = row;
		e.col_index  = col;
		e.value_bits = value;
		e.last_entry = last;
		return e;
	endfunction

	// Key modes: full range, a narrow range that forces ties, corner values,
	// and a few rows with wide columns.
	function automatic coo_in_t make_entry(int mode, logic last);
		logic [15:0] row;
		logic [15:0] col;
		case (mode)
			0: begin
				row = 16'($urandom);
				col = 16'($urandom);
			end
			1: begin
				row = 16'($urandom_range(3));
				col = 16'($urandom_range(3));
			end
			2: begin
				row = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				col = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			end
			default: begin
				row = 16'($urandom_range(7));
				col = 16'($urandom);
			end
		endcase
		return make_fields(row, col, $urandom, last);
	endfunction

	// Offer one entry, optionally after a sender gap; return at the rising
	// edge that completes the transfer. Called at a rising edge.
	task automatic send_entry(input coo_in_t e);
		int gap;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			entries_ch.valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		entries_ch.valid <= 1'b1;
		entries_ch.data  <= e;
		@(negedge clk);
		while (!entries_ch.ready)
			@(negedge clk);
		sb.note_entry(e);
		@(posedge clk);
	endtask

	task automatic send_set(input int count, input int mode);
		for (int i = 0; i < count; i++)
			send_entry(make_entry(mode, i == count - 1));
	endtask

	// Mostly short sets so many sorted runs come out; now and then a longer one.
	task automatic send_random_sets(input int budget);
		int sent;
		int count;
		sent = 0;
		while (sent < budget) begin
			count = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 20);
			send_set(count, $urandom_range(3));
			sent += count;
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		entries_ch.valid = 1'b0;
		entries_ch.data  = '0;
		results_ch.ready = 1'b0;
		send_idle_pct    = 35;
		recv_idle_pct    = 62;
		hold_token       = 0;
		hold_seen        = 0;
		hold_left        = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single-entry sets at the all-ones and all-zeros corners.
		send_entry(make_fields(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
		send_entry(make_fields(16'h0000, 16'h0000, 32'h0000_0000, 1'b1));
		// Equal keys interleaved with smaller and larger ones: ties must
		// keep arrival order, rows must win over columns.
		send_entry(make_fields(16'h0005, 16'h0009, 32'h0000_000A, 1'b0));
		send_entry(make_fields(16'h0005, 16'h0009, 32'h0000_000B, 1'b0));
		send_entry(make_fields(16'h0005, 16'h0002, 32'h8000_0000, 1'b0));
		send_entry(make_fields(16'h0000, 16'hFFFF, 32'h7FFF_FFFF, 1'b0));
		send_entry(make_fields(16'hFFFF, 16'h0000, 32'h5555_5555, 1'b0));
		send_entry(make_fields(16'h0005, 16'h0009, 32'h0000_000C, 1'b1));
		// Strictly descending rows: every insertion walks the whole store.
		for (int i = 4; i >= 0; i--)
			send_entry(make_fields(16'(i), 16'(8 - i), 32'hAAAA_0000 | 32'(i), i == 0));
		// Ascending columns in one row: every insertion stops at once.
		for (int i = 0; i < 4; i++)
			send_entry(make_fields(16'h1234, 16'(i * 16'h4000), 32'hC0DE_0000 | 32'(i),
				i == 3));

		// Random, sender idling lightly and receiver heavily.
		send_random_sets(70);

		// Swap the idle rates.
		send_idle_pct = 62;
		recv_idle_pct = 35;
		send_random_sets(70);

		// No idling. Hold off the receiver while a set streams in behind it.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_token++;
		send_set(20, 1);
		send_random_sets(20);
		// Fill the store exactly: the largest run, still without overflow.
		send_set(MAX_ENTRIES, 1);
		// Overrun the store by two; the dropped final entry still flushes.
		send_set(MAX_ENTRIES + 2, 0);
		// Overflow is sticky: later runs must still carry it.
		send_random_sets(20);

		entries_ch.valid <= 1'b0;
		while (sb.due_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.due_results.size() != 0) begin
			$error("%0d results never arrived", sb.due_results.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
